### sv/sild_pkg.sv
package sild_pkg;

	localparam int MAX_LINES = 32;
	localparam int CNT_W     = 6;
	localparam int IDX_W     = 5;

	typedef enum logic [1:0] {
		MODE_EDGE   = 2'd0,
		MODE_TICK   = 2'd1,
		MODE_MASK   = 2'd2,
		MODE_UNMASK = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_LINE_COUNT    = 2'd0,
		REG_FALLING_LINES = 2'd1,
		REG_RISING_LINES  = 2'd2,
		REG_LEVEL_LINES   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0]     line_count;
		logic [MAX_LINES-1:0] falling_lines;
		logic [MAX_LINES-1:0] rising_lines;
		logic [MAX_LINES-1:0] level_lines;
	} cfg_t;

	typedef struct packed {
		logic                 common_level;
		logic [MAX_LINES-1:0] line_levels;
		logic [IDX_W-1:0]     line_index;
		mode_t                mode;
	} item_t;

	typedef struct packed {
		logic                 poll_active;
		logic [MAX_LINES-1:0] pending_mask;
		logic [MAX_LINES-1:0] fire_mask;
	} res_t;

endpackage

### sv/sild_core.sv
module sild_core import sild_pkg::*; #(
	parameter int LINES = MAX_LINES
) (
	input  cfg_t             cfg,
	input  item_t            item,
	input  logic [LINES-1:0] enabled,
	input  logic [LINES-1:0] pending,
	input  logic             polling,
	output logic [LINES-1:0] enabled_nxt,
	output logic [LINES-1:0] pending_nxt,
	output logic             polling_nxt,
	output res_t             res
);

	localparam logic [CNT_W-1:0] LINES_CNT = CNT_W'(LINES);

	logic [CNT_W-1:0] n_eff;
	logic [LINES-1:0] in_use;
	logic [LINES-1:0] lev;
	logic [LINES-1:0] fall;
	logic [LINES-1:0] rise;
	logic [LINES-1:0] lvl;
	logic [LINES-1:0] cand;
	logic [LINES-1:0] lowest;
	logic [LINES-1:0] tick_fire;
	logic [LINES-1:0] tick_pend;
	logic [LINES-1:0] fire;
	logic             idx_ok;

	assign n_eff  = (cfg.line_count > LINES_CNT) ? LINES_CNT : cfg.line_count;
	assign lev    = item.line_levels[LINES-1:0];
	assign fall   = cfg.falling_lines[LINES-1:0];
	assign rise   = cfg.rising_lines[LINES-1:0];
	assign lvl    = cfg.level_lines[LINES-1:0];
	assign idx_ok = {1'b0, item.line_index} < n_eff;

	always_comb begin
		for (int i = 0; i < LINES; i++) begin
			in_use[i] = CNT_W'(i) < n_eff;
		end
	end

	// lowest enabled low falling line in use
	assign cand   = ~lev & enabled & fall & in_use;
	assign lowest = cand & (~cand + LINES'(1));

	always_comb begin
		for (int i = 0; i < LINES; i++) begin
			tick_fire[i] = 1'b0;
			tick_pend[i] = pending[i];
			if (in_use[i]) begin
				if (!lev[i]) begin
					tick_fire[i] = enabled[i] & fall[i] & (lvl[i] | ~pending[i]);
					tick_pend[i] = 1'b1;
				end else if (enabled[i] && pending[i]) begin
					tick_pend[i] = 1'b0;
				end else if (enabled[i] && rise[i]) begin
					tick_fire[i] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		enabled_nxt = enabled;
		pending_nxt = pending;
		polling_nxt = polling;
		fire        = '0;
		unique case (item.mode)
			MODE_EDGE: begin
				polling_nxt = 1'b1;
				if (!item.common_level) begin
					pending_nxt = lowest;
					fire        = lowest;
				end
			end
			MODE_TICK: begin
				if (polling) begin
					if (item.common_level) begin
						pending_nxt = '0;
						polling_nxt = 1'b0;
					end else begin
						pending_nxt = tick_pend;
						fire        = tick_fire;
					end
				end
			end
			MODE_MASK: begin
				for (int i = 0; i < LINES; i++) begin
					if (idx_ok && item.line_index == IDX_W'(i)) enabled_nxt[i] = 1'b0;
				end
			end
			MODE_UNMASK: begin
				for (int i = 0; i < LINES; i++) begin
					if (idx_ok && item.line_index == IDX_W'(i)) enabled_nxt[i] = 1'b1;
				end
			end
			default: begin
				fire = '0;
			end
		endcase
	end

	assign res.fire_mask    = MAX_LINES'(fire);
	assign res.pending_mask = MAX_LINES'(pending_nxt);
	assign res.poll_active  = polling_nxt;

endmodule

### sv/shared_irq_line_demux_unit.sv
// channel | dir | tdata (low bit up)                         | tuser
// s_*     | in  | line_index[4:0] line_levels[36:5] common[37] | mode[1:0]
// m_*     | out | fire_mask[31:0] pending_mask[63:32] poll[64] | -
// cfg_*   | in  | cfg_index selects register, cfg_data value   | -
//
// One item per cycle unless the output stalls. Path: input register,
// then the per-line update logic feeding the result register and state.
// Reset clears the configuration, the enable, pending and polling state
// and both valid flags; the item and result data registers are not reset.
// A stalled output holds its result; the input register takes an item
// while it is empty or its own item moves on to the result register.
module shared_irq_line_demux_unit import sild_pkg::*; #(
	parameter int LINES = MAX_LINES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // line_index, line_levels, common_level, pad
	input  logic [1:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // fire_mask, pending_mask, poll_active, pad
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t             cfg_q;
	item_t            item_s1;
	logic             valid_s1;
	res_t             res_s2;
	logic             valid_s2;
	logic [LINES-1:0] enabled_q;
	logic [LINES-1:0] pending_q;
	logic             polling_q;
	logic [LINES-1:0] enabled_nxt;
	logic [LINES-1:0] pending_nxt;
	logic             polling_nxt;
	res_t             res;
	item_t            item_in;
	logic             advance;

	assign item_in.mode         = mode_t'(s_tuser);
	assign item_in.line_index   = s_tdata[4:0];
	assign item_in.line_levels  = s_tdata[36:5];
	assign item_in.common_level = s_tdata[37];

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LINE_COUNT:    cfg_q.line_count    <= cfg_data[CNT_W-1:0];
				REG_FALLING_LINES: cfg_q.falling_lines <= cfg_data;
				REG_RISING_LINES:  cfg_q.rising_lines  <= cfg_data;
				REG_LEVEL_LINES:   cfg_q.level_lines   <= cfg_data;
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) item_s1 <= item_in;
	end

	sild_core #(
		.LINES(LINES)
	) u_core (
		.cfg         (cfg_q),
		.item        (item_s1),
		.enabled     (enabled_q),
		.pending     (pending_q),
		.polling     (polling_q),
		.enabled_nxt (enabled_nxt),
		.pending_nxt (pending_nxt),
		.polling_nxt (polling_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= '0;
			pending_q <= '0;
			polling_q <= 1'b0;
			valid_s2  <= 1'b0;
		end else if (advance) begin
			enabled_q <= enabled_nxt;
			pending_q <= pending_nxt;
			polling_q <= polling_nxt;
			valid_s2  <= 1'b1;
		end else if (m_tready) begin
			valid_s2  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res;
	end

`ifndef SYNTHESIS
	// pending bits only live while polling
	a_pend_needs_poll: assert property (@(posedge clk) disable iff (!arst_n)
		!polling_q |-> (pending_q == '0))
		else $error("pending set while not polling");

	a_edge_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.mode == MODE_EDGE) |=> $onehot0(res_s2.fire_mask))
		else $error("edge item fired more than one line");

	a_mask_no_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (item_s1.mode == MODE_MASK || item_s1.mode == MODE_UNMASK))
		|=> (res_s2.fire_mask == '0))
		else $error("mask item fired a line");
`endif

endmodule
